### rtl/efe_pkg.sv
// Shared types and constants for the escaped frame encoder.
`timescale 1ns / 1ps

package efe_pkg;

   localparam logic [7:0] START_BYTE = 8'h7E;
   localparam logic [7:0] ESC_BYTE   = 8'h7D;
   localparam logic [7:0] XON_BYTE   = 8'h11;
   localparam logic [7:0] XOFF_BYTE  = 8'h13;
   localparam logic [7:0] ESC_MASK   = 8'h20;
   localparam logic [7:0] CSUM_BASE  = 8'hFF;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic [15:0] frame_length;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       frame_end;
   } rsp_type;

   typedef struct packed {
      logic        has_hdr;
      logic [15:0] len;
      logic        has_data;
      logic [7:0]  data;
      logic        has_csum;
      logic [7:0]  csum;
   } job_type;

   typedef enum logic [2:0] {
      STEP_FIRST,
      STEP_START,
      STEP_LEN_HI,
      STEP_LEN_LO,
      STEP_DATA,
      STEP_CSUM
   } step_type;

endpackage

### rtl/efe_front.sv
// Front end: tracks frame position and checksum, turns each request into a job.
`timescale 1ns / 1ps

module efe_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  efe_pkg::req_type req,
   output efe_pkg::job_type job
);

   logic        in_frame_ff, in_frame_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [7:0]  running_sum_ff, running_sum_in;

   logic [15:0] left_base;
   logic [15:0] left_next;
   logic [7:0]  sum_base;
   logic [7:0]  sum_next;
   logic        zero_len;

   always_comb begin
      zero_len  = !in_frame_ff && (req.frame_length == 16'd0);
      left_base = in_frame_ff ? bytes_left_ff : req.frame_length;
      sum_base  = in_frame_ff ? running_sum_ff : 8'd0;
      left_next = left_base - 16'd1;
      sum_next  = sum_base + req.data_byte;

      job.has_hdr  = !in_frame_ff;
      job.len      = req.frame_length;
      job.has_data = !zero_len;
      job.data     = req.data_byte;
      job.has_csum = zero_len || (left_next == 16'd0);
      job.csum     = zero_len ? efe_pkg::CSUM_BASE : (efe_pkg::CSUM_BASE - sum_next);

      in_frame_in    = in_frame_ff;
      bytes_left_in  = bytes_left_ff;
      running_sum_in = running_sum_ff;
      if (accept && !zero_len) begin
         if (left_next == 16'd0) begin
            in_frame_in    = 1'b0;
            bytes_left_in  = 16'd0;
            running_sum_in = 8'd0;
         end else begin
            in_frame_in    = 1'b1;
            bytes_left_in  = left_next;
            running_sum_in = sum_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff    <= 1'b0;
         bytes_left_ff  <= 16'd0;
         running_sum_ff <= 8'd0;
      end else begin
         in_frame_ff    <= in_frame_in;
         bytes_left_ff  <= bytes_left_in;
         running_sum_ff <= running_sum_in;
      end
   end

endmodule

### rtl/efe_queue.sv
// Job queue between the front end and the byte sequencer.
`timescale 1ns / 1ps

module efe_queue #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  efe_pkg::job_type wr_job,
   output logic             full,
   input  logic             rd_en,
   output efe_pkg::job_type rd_job,
   output logic             rd_valid
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   efe_pkg::job_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full     = (count_ff == FULL_CNT);
   assign rd_valid = (count_ff != '0);
   assign rd_job   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + CW'(1);
      end else if (!wr_en && rd_en) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/efe_back.sv
// Back end: walks each job byte by byte, inserts escapes, holds the output register.
`timescale 1ns / 1ps

module efe_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  efe_pkg::job_type job,
   output logic             job_pop,
   output logic             empty,
   input  logic             pop,
   output efe_pkg::rsp_type rsp
);

   efe_pkg::step_type step_ff, step_in;
   efe_pkg::step_type cur_step;
   logic              esc_ff, esc_in;
   logic              out_valid_ff, out_valid_in;
   efe_pkg::rsp_type  out_ff, out_in;

   logic       load_ok;
   logic       advance;
   logic [7:0] cur_byte;
   logic       stuff;
   logic       step_done;
   logic       last_step;

   assign load_ok = !out_valid_ff || pop;
   assign advance = job_valid && load_ok;
   assign empty   = !out_valid_ff;
   assign rsp     = out_ff;

   always_comb begin
      cur_step = step_ff;
      if (step_ff == efe_pkg::STEP_FIRST) begin
         cur_step = job.has_hdr ? efe_pkg::STEP_START : efe_pkg::STEP_DATA;
      end
      case (cur_step)
         efe_pkg::STEP_START:  cur_byte = efe_pkg::START_BYTE;
         efe_pkg::STEP_LEN_HI: cur_byte = job.len[15:8];
         efe_pkg::STEP_LEN_LO: cur_byte = job.len[7:0];
         efe_pkg::STEP_DATA:   cur_byte = job.data;
         efe_pkg::STEP_CSUM:   cur_byte = job.csum;
         default:              cur_byte = job.data;
      endcase
      stuff = (cur_step != efe_pkg::STEP_START) &&
              (cur_byte inside {efe_pkg::START_BYTE, efe_pkg::ESC_BYTE,
                                efe_pkg::XON_BYTE, efe_pkg::XOFF_BYTE});
      step_done = esc_ff || !stuff;
      last_step = (cur_step == efe_pkg::STEP_CSUM) ||
                  ((cur_step == efe_pkg::STEP_DATA) && !job.has_csum);
      job_pop   = advance && step_done && last_step;
   end

   // next step
   always_comb begin
      step_in = step_ff;
      esc_in  = esc_ff;
      if (advance) begin
         esc_in = !step_done;
         if (step_done) begin
            if (last_step) begin
               step_in = efe_pkg::STEP_FIRST;
            end else begin
               case (cur_step)
                  efe_pkg::STEP_START:  step_in = efe_pkg::STEP_LEN_HI;
                  efe_pkg::STEP_LEN_HI: step_in = efe_pkg::STEP_LEN_LO;
                  efe_pkg::STEP_LEN_LO: step_in = job.has_data ? efe_pkg::STEP_DATA
                                                               : efe_pkg::STEP_CSUM;
                  efe_pkg::STEP_DATA:   step_in = efe_pkg::STEP_CSUM;
                  default:              step_in = efe_pkg::STEP_FIRST;
               endcase
            end
         end else begin
            step_in = cur_step;
         end
      end
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (advance) begin
         out_valid_in     = 1'b1;
         out_in.out_byte  = esc_ff ? (cur_byte ^ efe_pkg::ESC_MASK)
                                   : (stuff ? efe_pkg::ESC_BYTE : cur_byte);
         out_in.run_last  = step_done && last_step;
         out_in.frame_end = step_done && (cur_step == efe_pkg::STEP_CSUM);
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= efe_pkg::STEP_FIRST;
         esc_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         esc_ff       <= esc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule

### rtl/escaped_frame_encoder_core.sv
// Top level of the escaped frame encoder.
`timescale 1ns / 1ps

// Byte-stuffed frame encoder with length header and checksum.
// Requests: one payload byte each, taken at a clock edge where push is high
// and full is low. frame_length is read only on the first byte of a frame.
// Results: one wire byte each, on rsp_data while empty is low, taken at an
// edge where pop is high. A frame's first byte yields 0x7E and the 16-bit
// length; its last byte is followed by the checksum (frame_end set). Length,
// payload and checksum bytes of value 0x7E, 0x7D, 0x11 or 0x13 go out as
// 0x7D and the byte XOR 0x20. run_last marks the last byte of a request.
// The first wire byte of a request passes through the job queue and the output
// register before it is shown. The sequencer emits one wire byte per cycle while
// the output register is empty or popped, and a request yields one wire byte (two
// for an escaped byte, up to nine for a frame's first/last byte); a job queue of
// QUEUE_DEPTH entries absorbs the difference. When pop stays low the output
// register holds, the queue fills and full rises. Reset clears the frame
// state, the queue and the output register's valid flag.
module escaped_frame_encoder_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  efe_pkg::req_type req_data,
   output logic             empty,
   input  logic             pop,
   output efe_pkg::rsp_type rsp_data
);

   efe_pkg::job_type front_job;
   efe_pkg::job_type head_job;
   logic             accept;
   logic             head_valid;
   logic             head_pop;

   assign accept = push && !full;

   efe_front u_front (
      .clock (clock),
      .reset (reset),
      .accept(accept),
      .req   (req_data),
      .job   (front_job)
   );

   efe_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept),
      .wr_job  (front_job),
      .full    (full),
      .rd_en   (head_pop),
      .rd_job  (head_job),
      .rd_valid(head_valid)
   );

   efe_back u_back (
      .clock    (clock),
      .reset    (reset),
      .job_valid(head_valid),
      .job      (head_job),
      .job_pop  (head_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp      (rsp_data)
   );

endmodule
